// File: rtl/wci_pkg.sv
// Package for the waveform centroid/intensity unit.
// Holds payload structs, sequencer states, register map and saturation helper.
// No dependencies.
package wci_pkg;

  localparam int unsigned MAX_SAMPLES = 256;
  localparam int unsigned ADDR_W      = $clog2(MAX_SAMPLES);
  localparam int unsigned CNT_W       = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned PSUM_W      = 25;
  localparam int unsigned WSUM_W      = 34;
  localparam int unsigned FRAC_W      = 16;
  localparam int unsigned NUM_W       = WSUM_W + FRAC_W;  // dividend magnitude
  localparam int unsigned POS_W       = NUM_W + 1;        // signed quotient
  localparam int unsigned STEP_W      = $clog2(NUM_W);
  localparam int unsigned PADDR_W     = 3;

  localparam logic [PADDR_W-1:0] REG_SAMPLE_LIMIT = 3'h0;
  localparam logic [CNT_W-1:0]   LIMIT_RESET      = CNT_W'(MAX_SAMPLES);

  typedef struct packed {
    logic signed [15:0] sample_value;
    logic               last_sample;
  } wci_in_t;

  typedef struct packed {
    logic signed [31:0] centroid_position;
    logic               centroid_valid;
    logic signed [31:0] centroid_intensity;
    logic [8:0]         samples_used;
  } wci_out_t;

  typedef enum logic [2:0] {
    ST_ACC,
    ST_DIV,
    ST_SGN,
    ST_SEL,
    ST_RD1,
    ST_MUL,
    ST_FIN
  } wci_state_e;

  function automatic logic signed [31:0] sat_q16(input logic signed [POS_W-1:0] v);
    logic signed [POS_W-1:0] hi;
    logic signed [POS_W-1:0] lo;
    hi = POS_W'(signed'(32'sh7fff_ffff));
    lo = -POS_W'(signed'(33'sh0_8000_0000));
    if (v > hi) begin
      sat_q16 = 32'sh7fff_ffff;
    end else if (v < lo) begin
      sat_q16 = 32'sh8000_0000;
    end else begin
      sat_q16 = v[31:0];
    end
  endfunction

endpackage

// File: rtl/waveform_centroid_intensity_unit.sv
// Waveform centroid and interpolated intensity, top level.
// Samples are accepted one per cycle until the last-marked sample of a waveform.
// That transfer is followed by NUM_W (50) restoring divider steps, then sign, segment select,
// two store reads and the slope multiply, then the output load, which waits for a free output
// register; the input is stalled until that load (a zero sum goes straight to the load).
// The shared divider step and the single store read port set the length of that sequence.
// Reset: sample_limit 256, sums and index cleared; the sample store is not cleared.
module waveform_centroid_intensity_unit
  import wci_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  wci_in_t            in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output wci_out_t           out_data_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  wci_state_e state_q, state_d;

  logic [CNT_W-1:0]         limit_q;
  logic [CNT_W-1:0]         idx_q;
  logic signed [PSUM_W-1:0] psum_q;
  logic signed [WSUM_W-1:0] wsum_q;

  logic signed [15:0] mem [MAX_SAMPLES];
  logic signed [15:0] rd_data_q;
  logic [ADDR_W-1:0]  rd_addr;

  logic [NUM_W-1:0]        quo_q;
  logic [PSUM_W:0]         rem_q;
  logic [PSUM_W-1:0]       den_q;
  logic                    neg_q;
  logic [STEP_W-1:0]       step_q;
  logic signed [POS_W-1:0] pos_q;
  logic [CNT_W-1:0]        n_q;
  logic                    vld_q;
  logic                    clamp_q;
  logic [ADDR_W-1:0]       k_q;
  logic [FRAC_W-1:0]       f_q;
  logic signed [15:0]      lo_q;
  logic signed [33:0]      prod_q;

  logic     out_valid_q;
  wci_out_t out_q;

  // handshake and control
  logic in_acc, out_free, out_load, cfg_wr;
  assign in_stall_o = (state_q != ST_ACC);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign out_load   = (state_q == ST_FIN) && out_free;
  assign cfg_wr     = psel && penable && pwrite && pready;
  assign pready     = 1'b1;
  assign prdata     = (paddr == REG_SAMPLE_LIMIT) ? 32'(limit_q) : 32'h0;

  // accumulation
  logic [CNT_W-1:0]         lim;
  logic                     use_smp;
  logic signed [PSUM_W-1:0] psum_fin;
  logic signed [WSUM_W-1:0] wsum_fin;
  logic [CNT_W-1:0]         n_fin;
  logic [CNT_W-1:0]         idx_inc;

  // shared multiplier: sample * (index + 1) while accumulating, slope * fraction later
  logic signed [16:0] mul_a, mul_b, diff;
  logic signed [33:0] prod;

  assign lim     = (limit_q > LIMIT_RESET) ? LIMIT_RESET : limit_q;
  assign use_smp = in_acc && (idx_q < lim);
  assign idx_inc = idx_q + CNT_W'(1);
  assign diff    = 17'(rd_data_q) - 17'(lo_q);
  assign mul_a   = (state_q == ST_MUL) ? diff : 17'(in_data_i.sample_value);
  assign mul_b   = (state_q == ST_MUL) ? signed'({1'b0, f_q})
                                       : signed'(17'(idx_inc));
  assign prod    = mul_a * mul_b;

  assign psum_fin = use_smp ? psum_q + PSUM_W'(in_data_i.sample_value) : psum_q;
  assign wsum_fin = use_smp ? wsum_q + WSUM_W'(prod) : wsum_q;
  assign n_fin    = use_smp ? idx_inc : idx_q;

  // divider step
  logic [PSUM_W:0]   rem_sh;
  logic              ge;
  logic [WSUM_W-1:0] wmag;
  logic [PSUM_W-1:0] pmag;
  assign rem_sh = {rem_q[PSUM_W-1:0], quo_q[NUM_W-1]};
  assign ge     = rem_sh >= {1'b0, den_q};
  assign wmag   = wsum_fin[WSUM_W-1] ? WSUM_W'(-wsum_fin) : WSUM_W'(wsum_fin);
  assign pmag   = psum_fin[PSUM_W-1] ? PSUM_W'(-psum_fin) : PSUM_W'(psum_fin);

  // interpolation segment select
  logic signed [POS_W-1:0] n_pos;
  logic                    below, above;
  assign n_pos = signed'(POS_W'({n_q, {FRAC_W{1'b0}}}));
  assign below = pos_q < POS_W'(signed'(18'sh1_0000));
  assign above = pos_q >= n_pos;

  logic [ADDR_W-1:0] n_last, k_sel;
  assign n_last = ADDR_W'(n_q - CNT_W'(1));
  assign k_sel  = pos_q[FRAC_W +: ADDR_W];

  always_comb begin
    unique case (state_q)
      ST_SEL:  rd_addr = below ? '0 : (above ? n_last : k_sel - ADDR_W'(1));
      ST_RD1:  rd_addr = k_q;
      default: rd_addr = k_q;
    endcase
  end

  // result
  logic signed [34:0] inten;
  assign inten = 35'(signed'({lo_q, {FRAC_W{1'b0}}})) + 35'(prod_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_ACC: if (in_acc && in_data_i.last_sample) begin
        state_d = (psum_fin != '0) ? ST_DIV : ST_FIN;
      end
      ST_DIV: if (step_q == '0) state_d = ST_SGN;
      ST_SGN: state_d = ST_SEL;
      ST_SEL: state_d = ST_RD1;
      ST_RD1: state_d = ST_MUL;
      ST_MUL: state_d = ST_FIN;
      ST_FIN: if (out_free) state_d = ST_ACC;
      default: state_d = ST_ACC;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_ACC;
      limit_q     <= LIMIT_RESET;
      idx_q       <= '0;
      psum_q      <= '0;
      wsum_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_wr && paddr == REG_SAMPLE_LIMIT) limit_q <= pwdata[CNT_W-1:0];
      if (in_acc) begin
        if (in_data_i.last_sample) begin
          idx_q  <= '0;
          psum_q <= '0;
          wsum_q <= '0;
        end else begin
          idx_q  <= n_fin;
          psum_q <= psum_fin;
          wsum_q <= wsum_fin;
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // sample store, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (use_smp) mem[idx_q[ADDR_W-1:0]] <= in_data_i.sample_value;
    rd_data_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_ACC: if (in_acc && in_data_i.last_sample) begin
        n_q    <= n_fin;
        vld_q  <= (psum_fin != '0);
        quo_q  <= {wmag, {FRAC_W{1'b0}}};
        rem_q  <= '0;
        den_q  <= pmag;
        neg_q  <= wsum_fin[WSUM_W-1] ^ psum_fin[PSUM_W-1];
        step_q <= STEP_W'(NUM_W - 1);
        pos_q  <= '0;
        lo_q   <= '0;
        prod_q <= '0;
      end
      ST_DIV: begin
        quo_q  <= {quo_q[NUM_W-2:0], ge};
        rem_q  <= ge ? rem_sh - {1'b0, den_q} : rem_sh;
        step_q <= step_q - STEP_W'(1);
      end
      ST_SGN: pos_q <= neg_q ? -signed'({1'b0, quo_q}) : signed'({1'b0, quo_q});
      ST_SEL: begin
        clamp_q <= below || above;
        k_q     <= k_sel;
        f_q     <= (below || above) ? '0 : pos_q[FRAC_W-1:0];
      end
      ST_RD1: lo_q <= rd_data_q;
      ST_MUL: prod_q <= clamp_q ? '0 : prod;
      ST_FIN: if (out_free) begin
        out_q.centroid_position  <= sat_q16(pos_q);
        out_q.centroid_valid     <= vld_q;
        out_q.centroid_intensity <= sat_q16(POS_W'(inten));
        out_q.samples_used       <= n_q;
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_last_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_data_i.last_sample |=> in_stall_o)
    else $error("input not stalled after final sample");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.centroid_valid |->
      out_data_o.centroid_position == '0 && out_data_o.centroid_intensity == '0)
    else $error("zero-sum result carries non-zero fields");

  a_index_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= LIMIT_RESET)
    else $error("sample index beyond store depth");

  a_fin_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FIN && out_free |=> out_valid_o && state_q == ST_ACC)
    else $error("result not transferred to output register");

endmodule
